// ----- hw/rtl/pat_pkg.sv -----
// Shared constants, action codes and index helper for the presence address table.
// No dependencies; used by the top level, both checkers and the testbench.
package pat_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int ADDR_W      = 48;
  localparam int RSSI_W      = 8;
  localparam int ACT_W       = 3;
  localparam int COUNT_OUT_W = 4;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [ACT_W-1:0] ACT_ADD    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ADVERT = 3'd4;

  localparam logic [RSSI_W-1:0] RSSI_THR_RESET = 8'hB0; // -80 dBm

  // Map a logical list position onto the circular storage, starting at head.
  function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] head,
                                                input logic [IDX_W-1:0] pos);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= (IDX_W+1)'(TABLE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(TABLE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/presence_address_table_top.sv -----
// Flow: the item is latched; for add, remove, query and advert with an address given,
// the list is scanned one entry per cycle through the RAM read port, then the result
// is committed; clear, unused codes or a missing address go straight to the commit.
// busy_o falls as done_o rises; results are strobed once and cannot be stalled.
// Reset (rst_ni low, async): list empty, detected flag clear, threshold -80 dBm.
// Depends on pat_pkg and pat_ram.
module presence_address_table_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [pat_pkg::ACT_W-1:0]         action_i,
  input  logic [pat_pkg::ADDR_W-1:0]        address_i,
  input  logic                              address_given_i,
  input  logic signed [pat_pkg::RSSI_W-1:0] signal_strength_i,
  input  logic                              cfg_we_i,
  input  logic signed [pat_pkg::RSSI_W-1:0] cfg_wdata_i,
  output logic                              done_o,
  output logic                              ok_o,
  output logic                              detected_o,
  output logic [pat_pkg::COUNT_OUT_W-1:0]   entry_count_o,
  output logic [pat_pkg::ADDR_W-1:0]        newest_address_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                        state_q, state_d;
  logic [pat_pkg::ACT_W-1:0]         act_q, act_d;
  logic [pat_pkg::ADDR_W-1:0]        addr_q, addr_d;
  logic                              given_q, given_d;
  logic signed [pat_pkg::RSSI_W-1:0] strength_q, strength_d;
  logic signed [pat_pkg::RSSI_W-1:0] thr_q;
  logic [pat_pkg::CNT_W-1:0]         count_q, count_d;
  logic [pat_pkg::IDX_W-1:0]         head_q, head_d;
  logic [pat_pkg::CNT_W-1:0]         rptr_q, rptr_d;
  logic [pat_pkg::CNT_W-1:0]         wptr_q, wptr_d;
  logic                              pend_q, pend_d;
  logic                              hit_q, hit_d;
  logic [pat_pkg::ADDR_W-1:0]        newest_q, newest_d;
  logic                              ok_q, ok_d;
  logic                              done_q, done_d;
  logic                              detected_q, detected_d;

  logic                              ram_we;
  logic [pat_pkg::IDX_W-1:0]         ram_waddr;
  logic [pat_pkg::ADDR_W-1:0]        ram_wdata;
  logic [pat_pkg::IDX_W-1:0]         ram_raddr;
  logic [pat_pkg::ADDR_W-1:0]        ram_rdata;

  logic                              accept;
  logic                              scan_need;
  logic                              issue;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign scan_need = address_given_i &&
                     (action_i == pat_pkg::ACT_ADD || action_i == pat_pkg::ACT_REMOVE ||
                      action_i == pat_pkg::ACT_QUERY || action_i == pat_pkg::ACT_ADVERT);
  assign issue     = rptr_q < count_q;
  assign ram_raddr = pat_pkg::phys_idx(head_q, rptr_q[pat_pkg::IDX_W-1:0]);

  pat_ram #(
    .Width (pat_pkg::ADDR_W),
    .Depth (pat_pkg::TABLE_DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer: latch the item, walk the list through the shared compare, then commit.
  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    addr_d     = addr_q;
    given_d    = given_q;
    strength_d = strength_q;
    count_d    = count_q;
    head_d     = head_q;
    rptr_d     = rptr_q;
    wptr_d     = wptr_q;
    pend_d     = 1'b0;
    hit_d      = hit_q;
    newest_d   = newest_q;
    ok_d       = ok_q;
    done_d     = 1'b0;
    detected_d = detected_q;
    ram_we     = 1'b0;
    ram_waddr  = head_q;
    ram_wdata  = addr_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_d      = action_i;
          addr_d     = address_i;
          given_d    = address_given_i;
          strength_d = signal_strength_i;
          rptr_d     = '0;
          wptr_d     = '0;
          hit_d      = 1'b0;
          state_d    = scan_need ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        // Compare the entry read last cycle; on remove, compact the survivors.
        if (pend_q) begin
          if (ram_rdata == addr_q) begin
            hit_d = 1'b1;
          end else if (act_q == pat_pkg::ACT_REMOVE) begin
            ram_we    = 1'b1;
            ram_waddr = pat_pkg::phys_idx(head_q, wptr_q[pat_pkg::IDX_W-1:0]);
            ram_wdata = ram_rdata;
            wptr_d    = wptr_q + 1'b1;
            newest_d  = ram_rdata;
          end
        end
        // Advance the read pointer until every held entry is fetched.
        if (issue) begin
          rptr_d = rptr_q + 1'b1;
          pend_d = 1'b1;
        end else if (!pend_q) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        ok_d    = 1'b0;
        done_d  = 1'b1;
        state_d = ST_IDLE;
        unique case (act_q)
          pat_pkg::ACT_ADD: begin
            if (given_q && !hit_q) begin
              ram_we    = 1'b1;
              ram_wdata = addr_q;
              newest_d  = addr_q;
              ok_d      = 1'b1;
              if (count_q < pat_pkg::CNT_W'(pat_pkg::TABLE_DEPTH)) begin
                ram_waddr = pat_pkg::phys_idx(head_q, count_q[pat_pkg::IDX_W-1:0]);
                count_d   = count_q + 1'b1;
              end else begin
                // Full list: overwrite the oldest slot and move the head past it.
                ram_waddr = head_q;
                head_d    = pat_pkg::phys_idx(head_q, pat_pkg::IDX_W'(1));
              end
            end
          end
          pat_pkg::ACT_REMOVE: begin
            if (given_q) begin
              count_d = wptr_q;
              ok_d    = hit_q;
            end
          end
          pat_pkg::ACT_CLEAR: begin
            count_d = '0;
            head_d  = '0;
          end
          pat_pkg::ACT_QUERY: begin
            ok_d = hit_q;
          end
          pat_pkg::ACT_ADVERT: begin
            if (hit_q && (strength_q >= thr_q)) begin
              ok_d       = 1'b1;
              detected_d = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      head_q     <= '0;
      pend_q     <= 1'b0;
      done_q     <= 1'b0;
      detected_q <= 1'b0;
      thr_q      <= pat_pkg::RSSI_THR_RESET;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      head_q     <= head_d;
      pend_q     <= pend_d;
      done_q     <= done_d;
      detected_q <= detected_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // Item payload and scan bookkeeping.
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    addr_q     <= addr_d;
    given_q    <= given_d;
    strength_q <= strength_d;
    rptr_q     <= rptr_d;
    wptr_q     <= wptr_d;
    hit_q      <= hit_d;
    newest_q   <= newest_d;
    ok_q       <= ok_d;
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign ok_o             = ok_q;
  assign detected_o       = detected_q;
  assign entry_count_o    = pat_pkg::COUNT_OUT_W'(count_q);
  assign newest_address_o = (count_q == '0) ? '0 : newest_q;

endmodule

// ----- hw/rtl/pat_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the address entries of the table.
module pat_ram #(
  parameter int Width = 48,
  parameter int Depth = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write on enable, read every cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/pat_checker.sv -----
// Port-level checks for the presence address table, bound to the top level.
// Depends on pat_pkg and presence_address_table_top.
module pat_port_props (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_i,
  input logic                              done_i,
  input logic                              ok_i,
  input logic                              detected_i,
  input logic [pat_pkg::COUNT_OUT_W-1:0]   entry_count_i,
  input logic [pat_pkg::ADDR_W-1:0]        newest_address_i
);

  // A result only appears once the item is finished.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> !busy_i)
    else $error("done strobe while busy");

  // An accepted transfer keeps the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i) |=> busy_i)
    else $error("accepted start did not raise busy");

  // The detected flag never drops without a reset.
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    detected_i |=> detected_i)
    else $error("detected flag cleared");

  // An empty list shows no newest address.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && entry_count_i == '0) |-> (newest_address_i == '0))
    else $error("newest address nonzero on empty list");

  // Each result is strobed for a single cycle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !done_i)
    else $error("done strobe longer than one cycle");

  // Status bit is only meaningful alongside the strobe.
  logic unused_ok;
  assign unused_ok = ok_i;

endmodule

bind presence_address_table_top pat_port_props u_port_props (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_i           (busy_o),
  .done_i           (done_o),
  .ok_i             (ok_o),
  .detected_i       (detected_o),
  .entry_count_i    (entry_count_o),
  .newest_address_i (newest_address_o)
);

// ----- tb/pat_checker.sv -----
// Checker for the presence address table: watches the command, configuration and
// result ports, predicts each result and compares it field by field. Depends on pat_pkg.
`timescale 1ns / 1ps

module pat_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic [pat_pkg::ACT_W-1:0]         action_i,
  input  logic [pat_pkg::ADDR_W-1:0]        address_i,
  input  logic                              address_given_i,
  input  logic signed [pat_pkg::RSSI_W-1:0] signal_strength_i,
  input  logic                              cfg_we_i,
  input  logic signed [pat_pkg::RSSI_W-1:0] cfg_wdata_i,
  input  logic                              done_i,
  input  logic                              ok_i,
  input  logic                              detected_i,
  input  logic [pat_pkg::COUNT_OUT_W-1:0]   entry_count_i,
  input  logic [pat_pkg::ADDR_W-1:0]        newest_address_i,
  output int                                pending_o,
  output int                                error_count_o
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                            ok;
    logic                            detected;
    logic [pat_pkg::COUNT_OUT_W-1:0] entry_count;
    logic [pat_pkg::ADDR_W-1:0]      newest_address;
  } table_status_t;

  // Shadow copy of the list, the sticky flag and the threshold
  logic [pat_pkg::ADDR_W-1:0]        list_entries [pat_pkg::TABLE_DEPTH];
  int unsigned                       list_count;
  logic                              detected_seen;
  logic signed [pat_pkg::RSSI_W-1:0] rssi_threshold_q;

  table_status_t expected_status [$];
  table_status_t want;
  table_status_t next_status;

  function automatic logic is_listed(input logic [pat_pkg::ADDR_W-1:0] addr);
    for (int i = 0; i < list_count; i++) begin
      if (list_entries[i] == addr) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one action to the shadow list and return the status it reports
  function automatic table_status_t apply_action(
    input logic [pat_pkg::ACT_W-1:0]         act,
    input logic [pat_pkg::ADDR_W-1:0]        addr,
    input logic                              given,
    input logic signed [pat_pkg::RSSI_W-1:0] rssi
  );
    table_status_t st;
    int unsigned   wr;
    logic          hit;
    st  = '0;
    hit = 1'b0;
    case (act)
      pat_pkg::ACT_ADD: begin
        if (given && !is_listed(addr)) begin
          // full list: drop the oldest entry before appending
          if (list_count >= pat_pkg::TABLE_DEPTH) begin
            for (int i = 1; i < pat_pkg::TABLE_DEPTH; i++) list_entries[i-1] = list_entries[i];
            list_count = pat_pkg::TABLE_DEPTH - 1;
          end
          list_entries[list_count] = addr;
          list_count++;
          hit = 1'b1;
        end
      end
      pat_pkg::ACT_REMOVE: begin
        if (given) begin
          // delete every match and close the gap, keeping order
          wr = 0;
          for (int rd = 0; rd < list_count; rd++) begin
            if (list_entries[rd] == addr) begin
              hit = 1'b1;
            end else begin
              list_entries[wr] = list_entries[rd];
              wr++;
            end
          end
          list_count = wr;
        end
      end
      pat_pkg::ACT_CLEAR: begin
        list_count = 0;
      end
      pat_pkg::ACT_QUERY: begin
        hit = given && is_listed(addr);
      end
      pat_pkg::ACT_ADVERT: begin
        if (given && is_listed(addr) && rssi >= rssi_threshold_q) begin
          hit           = 1'b1;
          detected_seen = 1'b1;
        end
      end
      default: begin
      end
    endcase
    st.ok             = hit;
    st.detected       = detected_seen;
    st.entry_count    = pat_pkg::COUNT_OUT_W'(list_count);
    st.newest_address = (list_count > 0) ? list_entries[list_count-1] : '0;
    return st;
  endfunction

  task automatic log_error(input string msg);
    error_count_o++;
    if (error_count_o <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  // Compare each result transfer, then track configuration and new commands
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pat_pkg::TABLE_DEPTH; i++) list_entries[i] = '0;
      list_count       = 0;
      detected_seen    = 1'b0;
      rssi_threshold_q = pat_pkg::RSSI_THR_RESET;
      expected_status.delete();
      pending_o        = 0;
      error_count_o    = 0;
    end else begin
      if (done_i) begin
        if (expected_status.size() == 0) begin
          log_error($sformatf("unexpected result: ok=%b det=%b count=%0d newest=%h",
                              ok_i, detected_i, entry_count_i, newest_address_i));
        end else begin
          want = expected_status.pop_front();
          if (ok_i !== want.ok || detected_i !== want.detected ||
              entry_count_i !== want.entry_count ||
              newest_address_i !== want.newest_address) begin
            log_error($sformatf({"result mismatch: exp ok=%b det=%b count=%0d newest=%h,",
                                 " got ok=%b det=%b count=%0d newest=%h"},
                                want.ok, want.detected, want.entry_count,
                                want.newest_address, ok_i, detected_i, entry_count_i,
                                newest_address_i));
          end
        end
      end
      if (cfg_we_i) rssi_threshold_q = cfg_wdata_i;
      if (start_i && !busy_i) begin
        next_status     = apply_action(action_i, address_i, address_given_i,
                                       signal_strength_i);
        expected_status = {expected_status, next_status};
      end
      pending_o = expected_status.size();
    end
  end

endmodule

// ----- tb/tb_presence_address_table_top.sv -----
// Testbench top for the presence address table: drives directed and random commands
// and threshold writes, and reports the verdict. Depends on pat_pkg, pat_checker and presence_address_table_top.
`timescale 1ns / 1ps

module tb_presence_address_table_top;

  localparam logic [pat_pkg::ACT_W-1:0] ACT_RESERVED_FIRST = 3'd5;
  localparam logic [pat_pkg::ACT_W-1:0] ACT_RESERVED_LAST  = 3'd7;
  localparam int                        PHASES             = 8;
  localparam int                        ITEMS_PER_PHASE    = 125;
  localparam int                        POOL_SIZE          = 12;

  logic                              clk;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic [pat_pkg::ACT_W-1:0]         action;
  logic [pat_pkg::ADDR_W-1:0]        address;
  logic                              address_given;
  logic signed [pat_pkg::RSSI_W-1:0] signal_strength;
  logic                              cfg_we;
  logic signed [pat_pkg::RSSI_W-1:0] cfg_wdata;
  logic                              done;
  logic                              ok;
  logic                              detected;
  logic [pat_pkg::COUNT_OUT_W-1:0]   entry_count;
  logic [pat_pkg::ADDR_W-1:0]        newest_address;
  int                                pending;
  int                                error_count;

  int                                current_threshold;
  logic                              no_gaps;
  logic [pat_pkg::ADDR_W-1:0]        addr_pool [POOL_SIZE];

  presence_address_table_top i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .start_i           (start),
    .busy_o            (busy),
    .action_i          (action),
    .address_i         (address),
    .address_given_i   (address_given),
    .signal_strength_i (signal_strength),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .done_o            (done),
    .ok_o              (ok),
    .detected_o        (detected),
    .entry_count_o     (entry_count),
    .newest_address_o  (newest_address)
  );

  pat_checker i_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .start_i           (start),
    .busy_i            (busy),
    .action_i          (action),
    .address_i         (address),
    .address_given_i   (address_given),
    .signal_strength_i (signal_strength),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .done_i            (done),
    .ok_i              (ok),
    .detected_i        (detected),
    .entry_count_i     (entry_count),
    .newest_address_i  (newest_address),
    .pending_o         (pending),
    .error_count_o     (error_count)
  );

  // Free-running clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #5000000;
    $display("presence_address_table_top verification failed");
    $finish;
  end

  function automatic logic [pat_pkg::ADDR_W-1:0] rand_addr();
    return pat_pkg::ADDR_W'({$urandom(), $urandom()});
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one command and hold it until the transfer, then idle for a random gap that may be none
  task automatic send_action(input logic [pat_pkg::ACT_W-1:0] act,
                             input logic [pat_pkg::ADDR_W-1:0] addr,
                             input logic given,
                             input logic signed [pat_pkg::RSSI_W-1:0] rssi);
    int gap;
    @(negedge clk);
    action          = act;
    address         = addr;
    address_given   = given;
    signal_strength = rssi;
    start           = 1'b1;
    do @(posedge clk); while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop start and hold until every result has come back
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  task automatic write_threshold(input int value);
    wait_idle();
    cfg_we            = 1'b1;
    cfg_wdata         = pat_pkg::RSSI_W'(value);
    current_threshold = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Advert strength: often right around the threshold, otherwise anywhere
  function automatic logic signed [pat_pkg::RSSI_W-1:0] pick_rssi();
    int v;
    if ($urandom_range(0, 9) < 6) begin
      v = current_threshold + int'($urandom_range(0, 4)) - 2;
      if (v > 127) v = 127;
      if (v < -128) v = -128;
      return pat_pkg::RSSI_W'(v);
    end
    return pat_pkg::RSSI_W'($urandom_range(0, 255));
  endfunction

  task automatic send_random();
    int                         r;
    logic [pat_pkg::ACT_W-1:0]  act;
    logic [pat_pkg::ADDR_W-1:0] addr;
    logic                       given;
    r = $urandom_range(0, 99);
    if (r < 30)      act = pat_pkg::ACT_ADD;
    else if (r < 45) act = pat_pkg::ACT_REMOVE;
    else if (r < 50) act = pat_pkg::ACT_CLEAR;
    else if (r < 70) act = pat_pkg::ACT_QUERY;
    else if (r < 95) act = pat_pkg::ACT_ADVERT;
    else act = pat_pkg::ACT_W'($urandom_range(ACT_RESERVED_FIRST, ACT_RESERVED_LAST));
    addr  = ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                         : rand_addr();
    given = ($urandom_range(0, 9) != 0);
    send_action(act, addr, given,
                (act == pat_pkg::ACT_ADVERT) ? pick_rssi()
                                             : pat_pkg::RSSI_W'($urandom_range(0, 255)));
  endtask

  initial begin
    int                         phase_threshold [PHASES];
    logic [pat_pkg::ADDR_W-1:0] ones;
    logic [pat_pkg::ADDR_W-1:0] alt_lo;
    logic [pat_pkg::ADDR_W-1:0] alt_hi;

    phase_threshold = '{-128, 127, -80, 0, -1, -60, 0, 0};
    phase_threshold[6] = int'($urandom_range(0, 255)) - 128;
    phase_threshold[7] = int'($urandom_range(0, 255)) - 128;
    ones   = '1;
    alt_lo = {(pat_pkg::ADDR_W/2){2'b01}};
    alt_hi = {(pat_pkg::ADDR_W/2){2'b10}};

    // Known values on every input before and during reset
    rst_n             = 1'b0;
    start             = 1'b0;
    action            = pat_pkg::ACT_QUERY;
    address           = '0;
    address_given     = 1'b0;
    signal_strength   = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    current_threshold = -80;
    no_gaps           = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty list, refused and duplicate adds, overflow, adverts at the edge
    send_action(pat_pkg::ACT_QUERY,  '0,     1'b1, 8'sd0);
    send_action(pat_pkg::ACT_ADVERT, ones,   1'b1, 8'sd127);
    send_action(pat_pkg::ACT_ADD,    alt_lo, 1'b0, 8'sd0);
    send_action(pat_pkg::ACT_ADD,    '0,     1'b1, 8'sd0);
    send_action(pat_pkg::ACT_ADD,    ones,   1'b1, 8'sd0);
    send_action(pat_pkg::ACT_ADD,    ones,   1'b1, 8'sd0);
    send_action(pat_pkg::ACT_ADD,    alt_lo, 1'b1, 8'sd0);
    send_action(pat_pkg::ACT_ADD,    alt_hi, 1'b1, 8'sd0);
    repeat (5) send_action(pat_pkg::ACT_ADD, rand_addr(), 1'b1, 8'sd0);
    send_action(pat_pkg::ACT_QUERY,  '0,     1'b1, 8'sd0);
    send_action(pat_pkg::ACT_QUERY,  ones,   1'b0, 8'sd0);
    send_action(pat_pkg::ACT_ADVERT, ones,   1'b1, -8'sd80);
    send_action(pat_pkg::ACT_ADVERT, alt_lo, 1'b1, -8'sd81);
    send_action(pat_pkg::ACT_ADVERT, alt_hi, 1'b1, 8'sd127);
    send_action(pat_pkg::ACT_ADVERT, alt_lo, 1'b1, 8'sh80);
    send_action(pat_pkg::ACT_REMOVE, ones,   1'b0, 8'sd0);
    send_action(pat_pkg::ACT_REMOVE, ones,   1'b1, 8'sd0);
    send_action(pat_pkg::ACT_REMOVE, ones,   1'b1, 8'sd0);
    send_action(ACT_RESERVED_FIRST,  alt_hi, 1'b1, 8'sd0);
    send_action(ACT_RESERVED_LAST,   alt_hi, 1'b1, 8'sd0);
    send_action(pat_pkg::ACT_CLEAR,  alt_hi, 1'b1, 8'sd0);
    send_action(pat_pkg::ACT_QUERY,  alt_hi, 1'b1, 8'sd0);

    // Random phases, each under its own threshold and address pool
    for (int p = 0; p < PHASES; p++) begin
      write_threshold(phase_threshold[p]);
      foreach (addr_pool[i]) addr_pool[i] = rand_addr();
      if (p == 0) begin
        addr_pool[0] = '0;
        addr_pool[1] = ones;
      end
      no_gaps = (p % 3 == 1);
      repeat (ITEMS_PER_PHASE) send_random();
    end

    // Drain, then let the block settle
    wait_idle();
    repeat (20) @(negedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("presence_address_table_top verification clean");
    end else begin
      $display("presence_address_table_top verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/pat_pkg.sv
hw/rtl/pat_ram.sv
hw/rtl/presence_address_table_top.sv
hw/rtl/pat_checker.sv
tb/pat_checker.sv
tb/tb_presence_address_table_top.sv
